// ===== sv/xcfp_pkg.sv =====
// shared constants and helpers for the checksummed target frame parser
// depends on nothing; imported by xor_checked_target_frame_parser
package xcfp_pkg;

  // default upper bound on body length, overridable on the top level
  localparam int MAX_BODY_DEF = 47;

  // frame characters
  localparam logic [7:0] CH_START   = 8'h24;  // '$'
  localparam logic [7:0] CH_STAR    = 8'h2A;  // '*'
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LC_A    = 8'h61;
  localparam logic [7:0] CH_LC_F    = 8'h66;
  localparam logic [7:0] CH_UC_A    = 8'h41;
  localparam logic [7:0] CH_UC_F    = 8'h46;

  // frame status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CSUM    = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  // configuration register indexes
  localparam logic CFG_DIR_LIMIT = 1'b0;
  localparam logic CFG_NO_TARGET = 1'b1;

  // configuration reset values
  localparam logic [6:0] DIR_LIMIT_RST = 7'd100;
  localparam logic [7:0] NO_TARGET_RST = 8'd88;    // 'X'

  // position within the body
  localparam logic [2:0] FI_TYPE  = 3'd0;
  localparam logic [2:0] FI_COMMA = 3'd1;
  localparam logic [2:0] FI_X     = 3'd2;
  localparam logic [2:0] FI_Y     = 3'd3;
  localparam logic [2:0] FI_AREA  = 3'd4;
  localparam logic [2:0] FI_DIR   = 3'd5;
  localparam logic [2:0] FI_DONE  = 3'd6;

  typedef enum logic [1:0] {
    PH_SEEK = 2'd0,
    PH_BODY = 2'd1,
    PH_HEX  = 2'd2
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t h;
    h.ok  = 1'b1;
    h.val = b[3:0];
    if (b >= CH_ZERO && b <= CH_NINE) begin
      h.val = b[3:0];
    end else if ((b >= CH_LC_A && b <= CH_LC_F) || (b >= CH_UC_A && b <= CH_UC_F)) begin
      h.val = b[3:0] + 4'd9;
    end else begin
      h.ok  = 1'b0;
      h.val = 4'd0;
    end
    return h;
  endfunction

endpackage

// ===== sv/xor_checked_target_frame_parser.sv =====
// byte-serial parser for '$'-framed target sentences with an xor checksum
// depends on xcfp_pkg
//
// Takes one received byte per cycle, back to back, unless in_stall is high,
// and gives one status transaction for each newline that closes a frame, in
// the cycle after it is taken. All parsing of a byte (xor, decimal accumulate by
// shift-and-add, hex digit, field store) is one short step between the
// frame state registers and the result register, so the rate is one byte
// per clock. The result register holds a finished status while out_stall is
// high; in that case in_stall is raised the same cycle and input is held.
// Configuration writes are always ready and take effect on the next byte.
module xor_checked_target_frame_parser import xcfp_pkg::*; #(
  parameter int MAX_BODY = MAX_BODY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         frame_status,
  output logic [7:0]         target_type,
  output logic signed [15:0] center_x,
  output logic signed [15:0] center_y,
  output logic signed [31:0] target_area,
  output logic signed [7:0]  direction,
  output logic               target_valid,
  output logic [31:0]        frames_ok,
  output logic [31:0]        checksum_errors,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);

  localparam int BL_W = $clog2(MAX_BODY + 2);
  localparam logic [BL_W-1:0] BL_MAX = BL_W'(MAX_BODY);
  localparam logic [BL_W-1:0] BL_SAT = BL_W'(MAX_BODY + 1);

  // configuration
  logic [6:0] direction_limit;
  logic [7:0] no_target_code;

  // frame state
  phase_t          phase, phase_next;
  logic [BL_W-1:0] body_length, body_length_next;
  logic [7:0]      running_xor, running_xor_next;
  logic [2:0]      field_index, field_index_next;
  logic            negative_flag, negative_flag_next;
  logic            sign_seen, sign_seen_next;
  logic            digit_seen, digit_seen_next;
  logic [31:0]     number_accum, number_accum_next;
  logic [7:0]      type_code, type_code_next;
  logic [15:0]     x_value, x_value_next;
  logic [15:0]     y_value, y_value_next;
  logic [31:0]     area_value, area_value_next;
  logic [31:0]     direction_value, direction_value_next;
  logic            format_ok, format_ok_next;
  logic [1:0]      hex_count, hex_count_next;
  logic [7:0]      received_sum, received_sum_next;
  logic [31:0]     ok_counter, ok_counter_next;
  logic [31:0]     error_counter, error_counter_next;

  logic            accept;
  logic            emit;
  logic [1:0]      status;
  logic [31:0]     store_val;
  logic            is_digit;
  hex_digit_t      hex;
  logic signed [31:0] dir_s;
  logic signed [31:0] lim_s;
  logic signed [31:0] dir_clamped;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = out_valid && out_stall;
  assign cfg_ready = 1'b1;

  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign hex       = hex_decode(rx_byte);
  assign store_val = negative_flag ? (32'd0 - number_accum) : number_accum;

  // phase sequencing
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_SEEK: begin
        if (rx_byte == CH_START) phase_next = PH_BODY;
      end
      PH_BODY: begin
        if (rx_byte == CH_NL) phase_next = PH_SEEK;
        else if (rx_byte == CH_STAR) phase_next = PH_HEX;
      end
      PH_HEX: begin
        if (rx_byte == CH_NL) phase_next = PH_SEEK;
      end
      default: phase_next = PH_SEEK;
    endcase
  end

  // per-byte datapath
  always_comb begin
    body_length_next     = body_length;
    running_xor_next     = running_xor;
    field_index_next     = field_index;
    negative_flag_next   = negative_flag;
    sign_seen_next       = sign_seen;
    digit_seen_next      = digit_seen;
    number_accum_next    = number_accum;
    type_code_next       = type_code;
    x_value_next         = x_value;
    y_value_next         = y_value;
    area_value_next      = area_value;
    direction_value_next = direction_value;
    format_ok_next       = format_ok;
    hex_count_next       = hex_count;
    received_sum_next    = received_sum;
    ok_counter_next      = ok_counter;
    error_counter_next   = error_counter;
    emit                 = 1'b0;
    status               = ST_BAD;

    case (phase)
      PH_SEEK: begin
        if (rx_byte == CH_START) begin
          body_length_next     = '0;
          running_xor_next     = '0;
          field_index_next     = FI_TYPE;
          negative_flag_next   = 1'b0;
          sign_seen_next       = 1'b0;
          digit_seen_next      = 1'b0;
          number_accum_next    = '0;
          type_code_next       = '0;
          x_value_next         = '0;
          y_value_next         = '0;
          area_value_next      = '0;
          direction_value_next = '0;
          format_ok_next       = 1'b1;
          hex_count_next       = '0;
          received_sum_next    = '0;
        end
      end
      PH_BODY: begin
        if (rx_byte == CH_NL) begin
          emit   = 1'b1;
          status = ST_BAD;
        end else if (rx_byte == CH_STAR) begin
          // close the body: the last number may end at the star
          if (format_ok) begin
            if (field_index == FI_DIR && digit_seen) begin
              direction_value_next = store_val;
              format_ok_next       = 1'b1;
              field_index_next     = FI_DONE;
            end else begin
              format_ok_next = (field_index == FI_DONE);
            end
          end
        end else begin
          running_xor_next = running_xor ^ rx_byte;
          if (body_length < BL_SAT) body_length_next = body_length + 1'b1;
          if (format_ok) begin
            if (field_index == FI_TYPE) begin
              type_code_next   = rx_byte;
              field_index_next = FI_COMMA;
            end else if (field_index == FI_COMMA) begin
              if (rx_byte == CH_COMMA) begin
                field_index_next   = FI_X;
                negative_flag_next = 1'b0;
                sign_seen_next     = 1'b0;
                digit_seen_next    = 1'b0;
                number_accum_next  = '0;
              end else begin
                format_ok_next = 1'b0;
              end
            end else if (field_index inside {[FI_X:FI_DIR]}) begin
              if (is_digit) begin
                // accum * 10 + digit
                number_accum_next = (number_accum << 3) + (number_accum << 1)
                                    + {28'd0, rx_byte[3:0]};
                digit_seen_next   = 1'b1;
              end else if (!digit_seen && !sign_seen &&
                           (rx_byte == CH_PLUS || rx_byte == CH_MINUS)) begin
                sign_seen_next     = 1'b1;
                negative_flag_next = (rx_byte == CH_MINUS);
              end else if (digit_seen && field_index == FI_DIR) begin
                direction_value_next = store_val;
                field_index_next     = FI_DONE;
              end else if (digit_seen && rx_byte == CH_COMMA) begin
                case (field_index)
                  FI_X:    x_value_next    = store_val[15:0];
                  FI_Y:    y_value_next    = store_val[15:0];
                  FI_AREA: area_value_next = store_val;
                  default: direction_value_next = store_val;
                endcase
                field_index_next   = field_index + 3'd1;
                negative_flag_next = 1'b0;
                sign_seen_next     = 1'b0;
                digit_seen_next    = 1'b0;
                number_accum_next  = '0;
              end else begin
                format_ok_next = 1'b0;
              end
            end
          end
        end
      end
      PH_HEX: begin
        if (rx_byte == CH_NL) begin
          emit = 1'b1;
          if (hex_count < 2'd2 || body_length == '0 || body_length > BL_MAX) begin
            status = ST_BAD;
          end else if (running_xor != received_sum) begin
            status             = ST_CSUM;
            error_counter_next = error_counter + 32'd1;
          end else if (!format_ok) begin
            status = ST_BAD;
          end else begin
            status          = ST_OK;
            ok_counter_next = ok_counter + 32'd1;
          end
        end else if (hex_count < 2'd2) begin
          if (hex.ok) begin
            received_sum_next = {received_sum[3:0], hex.val};
            hex_count_next    = hex_count + 2'd1;
          end else begin
            // bad digit: zero length marks the frame malformed at newline
            hex_count_next    = '0;
            received_sum_next = '0;
            format_ok_next    = 1'b0;
            body_length_next  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // direction clamp
  assign dir_s = direction_value;
  assign lim_s = $signed({25'd0, direction_limit});
  always_comb begin
    if (dir_s > lim_s) dir_clamped = lim_s;
    else if (dir_s < -lim_s) dir_clamped = -lim_s;
    else dir_clamped = dir_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_limit <= DIR_LIMIT_RST;
      no_target_code  <= NO_TARGET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIR_LIMIT: direction_limit <= cfg_data[6:0];
        CFG_NO_TARGET: no_target_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SEEK;
      body_length     <= '0;
      running_xor     <= '0;
      field_index     <= FI_TYPE;
      negative_flag   <= 1'b0;
      sign_seen       <= 1'b0;
      digit_seen      <= 1'b0;
      number_accum    <= '0;
      type_code       <= '0;
      x_value         <= '0;
      y_value         <= '0;
      area_value      <= '0;
      direction_value <= '0;
      format_ok       <= 1'b1;
      hex_count       <= '0;
      received_sum    <= '0;
      ok_counter      <= '0;
      error_counter   <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      body_length     <= body_length_next;
      running_xor     <= running_xor_next;
      field_index     <= field_index_next;
      negative_flag   <= negative_flag_next;
      sign_seen       <= sign_seen_next;
      digit_seen      <= digit_seen_next;
      number_accum    <= number_accum_next;
      type_code       <= type_code_next;
      x_value         <= x_value_next;
      y_value         <= y_value_next;
      area_value      <= area_value_next;
      direction_value <= direction_value_next;
      format_ok       <= format_ok_next;
      hex_count       <= hex_count_next;
      received_sum    <= received_sum_next;
      ok_counter      <= ok_counter_next;
      error_counter   <= error_counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      frame_status    <= status;
      target_type     <= (status == ST_OK) ? type_code : 8'd0;
      center_x        <= (status == ST_OK) ? $signed(x_value) : 16'sd0;
      center_y        <= (status == ST_OK) ? $signed(y_value) : 16'sd0;
      target_area     <= (status == ST_OK) ? $signed(area_value) : 32'sd0;
      direction       <= (status == ST_OK) ? dir_clamped[7:0] : 8'sd0;
      target_valid    <= (status == ST_OK) && (type_code != no_target_code);
      frames_ok       <= ok_counter_next;
      checksum_errors <= error_counter_next;
    end
  end

  a_counters_only_on_close: assert property (@(posedge clk) disable iff (rst)
    !(accept && emit) |=> (ok_counter == $past(ok_counter)) &&
                          (error_counter == $past(error_counter)))
    else $error("frame counter moved without a closing newline");

  a_seek_not_to_hex: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_SEEK) |=> phase != PH_HEX)
    else $error("checksum phase entered straight from hunting");

  a_field_index_range: assert property (@(posedge clk) disable iff (rst)
    field_index <= FI_DONE)
    else $error("field index past the last field");

  a_reject_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_status != ST_OK) |-> (!target_valid && target_type == 8'd0 &&
                                              target_area == 32'sd0))
    else $error("rejected frame carries target data");

  a_ok_status_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && emit && status == ST_OK) |=> ok_counter == $past(ok_counter) + 32'd1)
    else $error("accepted frame not counted");

endmodule

// ===== tb/tb_xor_checked_target_frame_parser.sv =====
// testbench for xor_checked_target_frame_parser: directed and random frame traffic
// with its own frame predictor and a scoreboard; depends on xcfp_pkg and the parser rtl
module tb_xor_checked_target_frame_parser;
  import xcfp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum {TAIL_GOOD, TAIL_WRONG, TAIL_SHORT, TAIL_BAD_DIGIT, TAIL_NO_STAR, TAIL_EXTRA}
    tail_kind_t;

  typedef struct {
    logic [1:0]         status;
    logic [7:0]         ttype;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [31:0] area;
    logic signed [7:0]  dir;
    logic               tvalid;
    logic [31:0]        n_ok;
    logic [31:0]        n_csum;
  } frame_report_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         frame_status;
  logic [7:0]         target_type;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic signed [31:0] target_area;
  logic signed [7:0]  direction;
  logic               target_valid;
  logic [31:0]        frames_ok;
  logic [31:0]        checksum_errors;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [7:0]         cfg_data;

  // predictor state
  phase_t      p_phase;
  logic [5:0]  p_len;
  logic [7:0]  p_xor;
  logic [2:0]  p_field;
  logic        p_neg, p_sign, p_digit, p_fmt;
  logic [31:0] p_acc;
  logic [7:0]  p_type;
  logic [15:0] p_x, p_y;
  logic [31:0] p_area, p_dir;
  logic [1:0]  p_hex_cnt;
  logic [7:0]  p_sum;
  logic [31:0] p_ok_cnt, p_err_cnt;
  logic [6:0]  p_dir_limit;
  logic [7:0]  p_no_target;

  frame_report_t frame_reports[$];
  logic [7:0]    body_q[$];
  int            errors = 0;
  int            bytes_sent = 0;
  int unsigned   cycle_count = 0;
  int            tx_idle_pct = 0;
  int            rx_stall_pct = 0;

  xor_checked_target_frame_parser u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .frame_status(frame_status),
    .target_type(target_type),
    .center_x(center_x),
    .center_y(center_y),
    .target_area(target_area),
    .direction(direction),
    .target_valid(target_valid),
    .frames_ok(frames_ok),
    .checksum_errors(checksum_errors),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_LC_A && b <= CH_LC_F) ||
           (b >= CH_UC_A && b <= CH_UC_F);
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) return 4'(b - CH_ZERO);
    if (b >= CH_LC_A && b <= CH_LC_F) return 4'(b - CH_LC_A + 8'd10);
    return 4'(b - CH_UC_A + 8'd10);
  endfunction

  function automatic void clear_number();
    p_neg = 1'b0;
    p_sign = 1'b0;
    p_digit = 1'b0;
    p_acc = '0;
  endfunction

  function automatic void open_frame();
    p_len = '0;
    p_xor = '0;
    p_field = FI_TYPE;
    clear_number();
    p_type = '0;
    p_x = '0;
    p_y = '0;
    p_area = '0;
    p_dir = '0;
    p_fmt = 1'b1;
    p_hex_cnt = '0;
    p_sum = '0;
  endfunction

  function automatic void store_field();
    logic [31:0] v;
    v = p_neg ? (32'd0 - p_acc) : p_acc;
    if (p_field == FI_X) p_x = v[15:0];
    else if (p_field == FI_Y) p_y = v[15:0];
    else if (p_field == FI_AREA) p_area = v;
    else p_dir = v;
  endfunction

  function automatic void body_char(input logic [7:0] b);
    if (!p_fmt) return;
    if (p_field == FI_TYPE) begin
      p_type = b;
      p_field = FI_COMMA;
    end else if (p_field == FI_COMMA) begin
      if (b == CH_COMMA) begin
        p_field = FI_X;
        clear_number();
      end else begin
        p_fmt = 1'b0;
      end
    end else if (p_field >= FI_X && p_field <= FI_DIR) begin
      if (b >= CH_ZERO && b <= CH_NINE) begin
        p_acc = p_acc * 32'd10 + {24'd0, b - CH_ZERO};
        p_digit = 1'b1;
      end else if (!p_digit && !p_sign && (b == CH_PLUS || b == CH_MINUS)) begin
        p_sign = 1'b1;
        p_neg = (b == CH_MINUS);
      end else if (p_digit && p_field == FI_DIR) begin
        // anything after the last number is ignored
        store_field();
        p_field = FI_DONE;
      end else if (p_digit && b == CH_COMMA) begin
        store_field();
        p_field = p_field + 3'd1;
        clear_number();
      end else begin
        p_fmt = 1'b0;
      end
    end
  endfunction

  function automatic void close_body();
    if (!p_fmt) return;
    if (p_field == FI_DIR && p_digit) begin
      store_field();
      p_field = FI_DONE;
    end
    if (p_field != FI_DONE) p_fmt = 1'b0;
  endfunction

  function automatic void post_report(input logic [1:0] st);
    frame_report_t r;
    logic signed [31:0] d, lim;
    logic good;
    good = (st == ST_OK);
    d = $signed(p_dir);
    lim = $signed({25'd0, p_dir_limit});
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    r.status = st;
    r.ttype = good ? p_type : 8'd0;
    r.cx = good ? $signed(p_x) : 16'sd0;
    r.cy = good ? $signed(p_y) : 16'sd0;
    r.area = good ? $signed(p_area) : 32'sd0;
    r.dir = good ? d[7:0] : 8'sd0;
    r.tvalid = good && (p_type != p_no_target);
    r.n_ok = p_ok_cnt;
    r.n_csum = p_err_cnt;
    frame_reports.push_back(r);
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic [1:0] st;
    case (p_phase)
      PH_BODY: begin
        if (b == CH_NL) begin
          p_phase = PH_SEEK;
          post_report(ST_BAD);
        end else if (b == CH_STAR) begin
          close_body();
          p_phase = PH_HEX;
        end else begin
          p_xor = p_xor ^ b;
          body_char(b);
          if (p_len < MAX_BODY_DEF + 1) p_len = p_len + 6'd1;
        end
      end
      PH_HEX: begin
        if (b == CH_NL) begin
          p_phase = PH_SEEK;
          if (p_hex_cnt < 2'd2 || p_len == 0 || p_len > MAX_BODY_DEF) begin
            st = ST_BAD;
          end else if (p_xor != p_sum) begin
            p_err_cnt = p_err_cnt + 32'd1;
            st = ST_CSUM;
          end else if (!p_fmt) begin
            st = ST_BAD;
          end else begin
            p_ok_cnt = p_ok_cnt + 32'd1;
            st = ST_OK;
          end
          post_report(st);
        end else if (p_hex_cnt < 2'd2) begin
          if (!is_hex(b)) begin
            // a bad digit poisons the whole frame
            p_hex_cnt = '0;
            p_sum = '0;
            p_fmt = 1'b0;
            p_len = '0;
          end else begin
            p_sum = {p_sum[3:0], nibble_of(b)};
            p_hex_cnt = p_hex_cnt + 2'd1;
          end
        end
      end
      default: begin
        if (b == CH_START) begin
          open_frame();
          p_phase = PH_BODY;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 50)
      $display("mismatch %s: got 0x%0h expected 0x%0h at cycle %0d", what, got, want,
               cycle_count);
    errors++;
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    frame_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frame_reports.size() == 0) begin
        report_mismatch("status with none pending", 32'(frame_status), 0);
      end else begin
        want = frame_reports.pop_front();
        compare_field("frame_status", 32'(frame_status), 32'(want.status));
        compare_field("target_type", 32'(target_type), 32'(want.ttype));
        compare_field("center_x", 32'(center_x), 32'(want.cx));
        compare_field("center_y", 32'(center_y), 32'(want.cy));
        compare_field("target_area", target_area, want.area);
        compare_field("direction", 32'(direction), 32'(want.dir));
        compare_field("target_valid", 32'(target_valid), 32'(want.tvalid));
        compare_field("frames_ok", frames_ok, want.n_ok);
        compare_field("checksum_errors", checksum_errors, want.n_csum);
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d status transactions pending", frame_reports.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      rx_byte <= 8'($urandom_range(0, 255));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b);
    bytes_sent++;
  endtask

  // waits until every status has come back, then lets the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (frame_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [6:0] lim, input logic [7:0] code);
    logic top_bit;
    top_bit = 1'($urandom_range(0, 1));
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DIR_LIMIT;
    cfg_data <= {top_bit, lim};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    p_dir_limit = lim;
    cfg_index <= CFG_NO_TARGET;
    cfg_data <= code;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    p_no_target = code;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    if (nib < 4'd10) return CH_ZERO + nib;
    return (upper ? CH_UC_A : CH_LC_A) + nib - 8'd10;
  endfunction

  function automatic logic [7:0] pick_byte(input logic hex_ok);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_NL || (!hex_ok && is_hex(b)));
    return b;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  task automatic send_sum(input logic [7:0] v);
    send_byte(hex_char(v[7:4], 1'($urandom_range(0, 1))));
    send_byte(hex_char(v[3:0], 1'($urandom_range(0, 1))));
  endtask

  task automatic send_frame(input tail_kind_t tail);
    logic [7:0] sum, flip;
    sum = '0;
    flip = 8'($urandom_range(1, 255));
    foreach (body_q[i]) sum = sum ^ body_q[i];
    send_byte(CH_START);
    foreach (body_q[i]) send_byte(body_q[i]);
    if (tail != TAIL_NO_STAR) send_byte(CH_STAR);
    case (tail)
      TAIL_GOOD, TAIL_EXTRA: send_sum(sum);
      TAIL_WRONG: send_sum(sum ^ flip);
      TAIL_SHORT: begin
        if ($urandom_range(0, 1)) send_byte(hex_char(sum[7:4], 1'b0));
      end
      TAIL_BAD_DIGIT: begin
        if ($urandom_range(0, 1)) send_byte(hex_char(sum[7:4], 1'b1));
        send_byte(pick_byte(1'b0));
        repeat ($urandom_range(0, 2)) send_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
      end
      default: ;
    endcase
    if (tail == TAIL_EXTRA) repeat ($urandom_range(1, 4)) send_byte(pick_byte(1'b1));
    send_byte(CH_NL);
    body_q.delete();
  endtask

  task automatic frame_text(input string s, input tail_kind_t tail);
    add_text(s);
    send_frame(tail);
  endtask

  task automatic add_number();
    int r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 20) body_q.push_back(CH_MINUS);
    else if (r < 35) body_q.push_back(CH_PLUS);
    r = $urandom_range(0, 99);
    if (r >= 90) begin
      // past 32 bits, wraps
      repeat ($urandom_range(11, 12)) body_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      return;
    end
    if (r < 35) v = $urandom_range(0, 999);
    else if (r < 55) v = $urandom_range(0, 140);
    else if (r < 75) v = $urandom;
    else begin
      case ($urandom_range(0, 5))
        0: v = 32'd32767;
        1: v = 32'd32768;
        2: v = 32'd65535;
        3: v = 32'd65536;
        4: v = 32'd2147483647;
        default: v = 32'd2147483648;
      endcase
    end
    add_text($sformatf("%0d", v));
  endtask

  task automatic build_random_body();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 3) return;
    if (r < 18) body_q.push_back(p_no_target);
    else if (r < 28) body_q.push_back(8'($urandom_range(0, 255)));
    else body_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
    body_q.push_back(CH_COMMA);
    for (int i = 0; i < 4; i++) begin
      if (i > 0) body_q.push_back(CH_COMMA);
      add_number();
    end
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 4)) begin
        c = 8'($urandom_range(8'h21, 8'h7E));
        body_q.push_back(c == CH_STAR ? CH_COMMA : c);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 8) body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(0, 255));
    else if (r < 12) body_q.insert($urandom_range(2, body_q.size() - 1), CH_MINUS);
    else if (r < 15) body_q.delete($urandom_range(0, body_q.size() - 1));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_field_extremes();
    frame_text("A,32767,-32768,2147483647,127", TAIL_GOOD);
    frame_text("B,65535,32768,-2147483648,-128", TAIL_GOOD);
    frame_text("C,+4294967295,-65536,4294967296,100", TAIL_GOOD);
    frame_text("D,0,-0,0,101", TAIL_GOOD);
    frame_text("D,9,9,9,-101", TAIL_GOOD);
    frame_text("X,1,2,3,4", TAIL_GOOD);
    body_q.push_back(8'hFF);
    frame_text(",-1,-2,-3,-4", TAIL_GOOD);
    body_q.push_back(8'h00);
    frame_text(",5,6,7,8", TAIL_GOOD);
    drain();
  endtask

  task automatic test_frame_faults();
    // noise and newline while hunting for a start
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_NL);
    send_byte(8'h41);
    frame_text("D,1,2,3,4$z", TAIL_GOOD);
    frame_text("D,1$,2,3,4", TAIL_GOOD);
    frame_text("H,1,2,3,4", TAIL_NO_STAR);
    send_frame(TAIL_GOOD);
    // body exactly at the bound, then one over
    add_text("E,1,2,3,");
    repeat (MAX_BODY_DEF - 9) body_q.push_back(CH_ZERO);
    frame_text("7", TAIL_GOOD);
    add_text("E,1,2,3,");
    repeat (MAX_BODY_DEF - 8) body_q.push_back(CH_ZERO);
    frame_text("7", TAIL_GOOD);
    frame_text("K,-7,8,9,10", TAIL_BAD_DIGIT);
    frame_text("K,-7,8,9,10", TAIL_SHORT);
    frame_text("K,-7,8,9,10", TAIL_EXTRA);
    frame_text("K,-7,8,9,10", TAIL_WRONG);
    frame_text("F1,2,3,4,5", TAIL_GOOD);
    frame_text("F,,1,2,3", TAIL_GOOD);
    frame_text("F,+-1,2,3,4", TAIL_GOOD);
    frame_text("F,+-1,2,3,4", TAIL_WRONG);
    frame_text("F,1a,2,3,4", TAIL_GOOD);
    frame_text("F,1,2,3", TAIL_GOOD);
    frame_text("F,1,2,3,-", TAIL_GOOD);
    frame_text("G,+1,2,3,4abc,d", TAIL_GOOD);
    drain();
  endtask

  task automatic test_config_extremes();
    set_config(7'd0, 8'h00);
    frame_text("A,5,6,7,50", TAIL_GOOD);
    frame_text("A,5,6,7,-50", TAIL_GOOD);
    body_q.push_back(8'h00);
    frame_text(",1,1,1,1", TAIL_GOOD);
    set_config(7'd127, 8'hFF);
    frame_text("B,1,1,1,127", TAIL_GOOD);
    frame_text("B,1,1,1,-128", TAIL_GOOD);
    frame_text("B,1,1,1,200", TAIL_GOOD);
    frame_text("X,0,0,0,0", TAIL_GOOD);
    body_q.push_back(8'hFF);
    frame_text(",2,2,2,2", TAIL_GOOD);
    set_config(DIR_LIMIT_RST, NO_TARGET_RST);
  endtask

  task automatic test_random_traffic();
    int start_bytes, frames, r;
    logic [6:0] lim;
    logic [7:0] code, b;
    tail_kind_t tail;
    for (int pass_no = 0; pass_no < 3; pass_no++) begin
      tx_idle_pct = (pass_no == 0) ? 36 : (pass_no == 1) ? 63 : 0;
      rx_stall_pct = (pass_no == 0) ? 63 : (pass_no == 1) ? 36 : 0;
      start_bytes = bytes_sent;
      frames = 0;
      while (bytes_sent - start_bytes < 180 || frames < 5) begin
        if (frames % 3 == 0) begin
          r = $urandom_range(0, 99);
          lim = (r < 25) ? 7'd0 : (r < 50) ? 7'd127 : 7'($urandom_range(0, 127));
          r = $urandom_range(0, 99);
          if (r < 20) code = 8'h00;
          else if (r < 40) code = 8'hFF;
          else if (r < 60) code = NO_TARGET_RST;
          else code = 8'($urandom_range(8'h41, 8'h5A));
          set_config(lim, code);
        end
        if ($urandom_range(0, 99) < 20) begin
          repeat ($urandom_range(1, 5)) begin
            b = 8'($urandom_range(0, 255));
            // a stray start mostly turns into a harmless newline
            if (b == CH_START && $urandom_range(0, 3) != 0) b = CH_NL;
            send_byte(b);
          end
        end
        build_random_body();
        r = $urandom_range(0, 99);
        if (r < 76) tail = TAIL_GOOD;
        else if (r < 83) tail = TAIL_WRONG;
        else if (r < 87) tail = TAIL_SHORT;
        else if (r < 91) tail = TAIL_BAD_DIGIT;
        else if (r < 95) tail = TAIL_NO_STAR;
        else tail = TAIL_EXTRA;
        send_frame(tail);
        frames++;
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    rx_byte <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_DIR_LIMIT;
    cfg_data <= '0;
    p_dir_limit = DIR_LIMIT_RST;
    p_no_target = NO_TARGET_RST;
    p_phase = PH_SEEK;
    open_frame();
    p_ok_cnt = '0;
    p_err_cnt = '0;
    tx_idle_pct = 36;
    rx_stall_pct = 63;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_frame_faults();
    test_config_extremes();
    test_random_traffic();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== xor_checked_target_frame_parser.f =====
sv/xcfp_pkg.sv
sv/xor_checked_target_frame_parser.sv
tb/tb_xor_checked_target_frame_parser.sv
